// File: hw/rtl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types, widths and helpers for the data rate register search block.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int unsigned TARGET_W   = 24;
  localparam int unsigned CRYSTAL_W  = 25;
  localparam int unsigned EXP_W      = 4;
  localparam int unsigned MANT_W     = 8;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned EXP_N      = 16;
  localparam int unsigned RATE_SHIFT = 28;

  // quotient bits needed: k = q >> e must reach 511 at the largest exponent
  localparam int unsigned QUOT_W      = 24;
  localparam int unsigned PRE_SHIFT   = RATE_SHIFT - QUOT_W;
  localparam int unsigned STEPS_PER   = 4;
  localparam int unsigned DIV_STAGES  = QUOT_W / STEPS_PER;

  // k = 256 + m, product and distance widths
  localparam int unsigned K_W    = 9;
  localparam int unsigned PROD_W = K_W + CRYSTAL_W;
  localparam int unsigned SHP_W  = PROD_W + EXP_N - 1;
  localparam int unsigned DIST_W = TARGET_W + RATE_SHIFT;

  localparam logic [K_W-1:0]     K_MIN       = 9'd256;
  localparam logic [K_W-1:0]     K_MAX       = 9'd511;
  localparam logic [QUOT_W-1:0]  Q_HI_LIMIT  = 24'd511;
  localparam logic [CRYSTAL_W-1:0] CRYSTAL_RESET = 25'd26000000;
  localparam logic [3:0]         NIBBLE_ZERO = 4'h0;

  // item riding along the pipeline
  typedef struct packed {
    logic                vld;
    logic [TARGET_W-1:0] target;
    logic [BYTE_W-1:0]   modem;
  } item_t;

  // one candidate of the search
  typedef struct packed {
    logic [EXP_W-1:0]  e;
    logic [K_W-1:0]    k;
    logic [DIST_W-1:0] d;
  } cand_t;

  // nearer of two candidates, the first one wins a tie
  function automatic cand_t pick_nearer(input cand_t a, input cand_t b);
    cand_t r;
    r = (b.d < a.d) ? b : a;
    return r;
  endfunction

endpackage

// File: hw/rtl/drs_if.sv
// ----------------------------------------------------------------------------
// drs_req_if / drs_rsp_if
// Valid/ready channels carrying a search request and its result.
// ----------------------------------------------------------------------------
interface drs_req_if;
  logic        valid;
  logic        ready;
  logic [23:0] target_bps;
  logic [7:0]  current_modem_byte;

  modport source (output valid, output target_bps, output current_modem_byte, input ready);
  modport sink   (input valid, input target_bps, input current_modem_byte, output ready);
endinterface

interface drs_rsp_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [3:0] rate_exponent;
  logic [7:0] rate_mantissa;
  logic [7:0] modem_byte_out;
  logic [7:0] mantissa_byte_out;

  modport source (output valid, output valid_res, output rate_exponent,
                  output rate_mantissa, output modem_byte_out,
                  output mantissa_byte_out, input ready);
  modport sink   (input valid, input valid_res, input rate_exponent,
                  input rate_mantissa, input modem_byte_out,
                  input mantissa_byte_out, output ready);
endinterface

// File: hw/rtl/drs_quot_pipe.sv
// ----------------------------------------------------------------------------
// drs_quot_pipe
// Pipelined restoring divider: q = floor(target * 2^28 / crystal), saturated
// to a flag when the quotient does not fit its bits.
// ----------------------------------------------------------------------------
module drs_quot_pipe (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [drs_pkg::CRYSTAL_W-1:0]  crystal,
  input  drs_pkg::item_t                 in_item,
  output drs_pkg::item_t                 out_item,
  output logic [drs_pkg::QUOT_W-1:0]     out_q,
  output logic                           out_ovf
);
  import drs_pkg::*;

  item_t                 item [DIV_STAGES+1];
  logic                  ovf  [DIV_STAGES+1];
  logic [CRYSTAL_W-1:0]  rem  [DIV_STAGES+1];
  logic [QUOT_W-1:0]     quot [DIV_STAGES+1];
  logic [CRYSTAL_W-1:0]  rem_next  [DIV_STAGES+1];
  logic [QUOT_W-1:0]     quot_next [DIV_STAGES+1];

  logic [RATE_SHIFT-1:0] pre;
  logic                  pre_ovf;

  // entry: top bits of the dividend and the overflow check
  always_comb begin
    pre      = {in_item.target, PRE_SHIFT'(0)};
    pre_ovf  = (pre >= RATE_SHIFT'(crystal));
  end

  assign rem_next[0]  = pre_ovf ? '0 : pre[CRYSTAL_W-1:0];
  assign quot_next[0] = '0;

  // four quotient bits per stage
  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
    always_comb begin : p_steps
      logic [CRYSTAL_W:0]   r2;
      logic [CRYSTAL_W-1:0] r;
      logic [QUOT_W-1:0]    q;
      logic                 b;
      r = rem[s-1];
      q = quot[s-1];
      for (int j = 0; j < STEPS_PER; j++) begin
        r2 = {r, 1'b0};
        b  = (r2 >= {1'b0, crystal});
        if (b) begin
          r2 = r2 - {1'b0, crystal};
        end
        r = r2[CRYSTAL_W-1:0];
        q = {q[QUOT_W-2:0], b};
      end
      rem_next[s]  = r;
      quot_next[s] = q;
    end
  end

  // stage registers, valid bits cleared by reset
  for (genvar s = 0; s <= DIV_STAGES; s++) begin : g_reg
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          item[0].vld <= 1'b0;
        end else if (en) begin
          item[0].vld <= in_item.vld;
        end
        if (en) begin
          item[0].target <= in_item.target;
          item[0].modem  <= in_item.modem;
          ovf[0]         <= pre_ovf;
          rem[0]         <= rem_next[0];
          quot[0]        <= quot_next[0];
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          item[s].vld <= 1'b0;
        end else if (en) begin
          item[s].vld <= item[s-1].vld;
        end
        if (en) begin
          item[s].target <= item[s-1].target;
          item[s].modem  <= item[s-1].modem;
          ovf[s]         <= ovf[s-1];
          rem[s]         <= rem_next[s];
          quot[s]        <= quot_next[s];
        end
      end
    end
  end

  assign out_item = item[DIV_STAGES];
  assign out_q    = quot[DIV_STAGES];
  assign out_ovf  = ovf[DIV_STAGES];

endmodule

// File: hw/rtl/data_rate_register_search.sv
// ----------------------------------------------------------------------------
// data_rate_register_search
// Nearest exponent/mantissa pair for a requested bit rate.
// ----------------------------------------------------------------------------
// Usage: a request on req (target_bps, current_modem_byte) gives one result
// on rsp: the exponent e and mantissa m whose rate (256+m)*2^e*crystal/2^28
// is nearest the target, with ties going to the smaller e, then smaller m.
// The user must write crystal_hz through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce it. A zero target returns
// valid_res 0 and all-zero fields. Throughput: one transfer per cycle on
// each side while rsp does not stall. A request passes the divider stages
// (24 quotient bits, four per stage), multiply, distance, neighbor pick, two
// compare-tree stages over the 16 exponents, and the output register.
// The pipeline moves as a whole: when rsp stalls with a result waiting,
// req.ready drops and every stage holds; nothing is lost or repeated.
// Reset clears all valid bits and loads crystal_hz with 26000000.
// ----------------------------------------------------------------------------
module data_rate_register_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [drs_pkg::CRYSTAL_W-1:0] cfg_wdata,
  drs_req_if.sink                       req,
  drs_rsp_if.source                     rsp
);
  import drs_pkg::*;

  logic                  en;
  logic [CRYSTAL_W-1:0]  crystal;
  item_t                 in_item;
  item_t                 dv_item;
  logic [QUOT_W-1:0]     dv_q;
  logic                  dv_ovf;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      crystal <= CRYSTAL_RESET;
    end else if (cfg_we) begin
      crystal <= cfg_wdata;
    end
  end

  // whole pipeline advances unless a finished result is held
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  assign in_item.vld    = req.valid;
  assign in_item.target = req.target_bps;
  assign in_item.modem  = req.current_modem_byte;

  drs_quot_pipe u_quot (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .crystal  (crystal),
    .in_item  (in_item),
    .out_item (dv_item),
    .out_q    (dv_q),
    .out_ovf  (dv_ovf)
  );

  // lane registers per exponent
  item_t               a_item, b_item, c_item, t1_item, t2_item;
  logic [PROD_W-1:0]   a_p  [EXP_N];
  logic [K_W-1:0]      a_k  [EXP_N];
  logic                a_lo [EXP_N];
  logic                a_hi [EXP_N];
  logic [DIST_W-1:0]   b_d  [EXP_N];
  logic [K_W-1:0]      b_k  [EXP_N];
  logic                b_mid[EXP_N];
  cand_t               c_cand [EXP_N];
  cand_t               t1_cand [4];
  cand_t               t2_cand;

  for (genvar e = 0; e < EXP_N; e++) begin : g_lane
    logic [QUOT_W-1:0] qs;
    logic              lo, hi;
    logic [K_W-1:0]    kk;
    logic [SHP_W-1:0]  sh;
    logic [DIST_W-1:0] g, dd;
    logic [DIST_W-1:0] ce, d2;

    // floor quotient for this exponent, clamped into the mantissa range
    always_comb begin
      qs = dv_q >> e;
      lo = !dv_ovf && (qs < QUOT_W'(K_MIN));
      hi = dv_ovf || (qs >= Q_HI_LIMIT);
      if (hi) begin
        kk = K_MAX;
      end else if (lo) begin
        kk = K_MIN;
      end else begin
        kk = qs[K_W-1:0];
      end
    end

    // distance of the lower candidate
    always_comb begin
      sh = SHP_W'(a_p[e]) << e;
      g  = {a_item.target, RATE_SHIFT'(0)};
      dd = a_lo[e] ? (DIST_W'(sh) - g) : (g - DIST_W'(sh));
    end

    // distance of the upper neighbor
    always_comb begin
      ce = DIST_W'(crystal) << e;
      d2 = ce - b_d[e];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_p[e]  <= PROD_W'(kk) * PROD_W'(crystal);
        a_k[e]  <= kk;
        a_lo[e] <= lo;
        a_hi[e] <= hi;
        b_d[e]  <= dd;
        b_k[e]  <= a_k[e];
        b_mid[e] <= !a_lo[e] && !a_hi[e];
        c_cand[e].e <= EXP_W'(e);
        if (b_mid[e] && (d2 < b_d[e])) begin
          c_cand[e].k <= b_k[e] + K_W'(1);
          c_cand[e].d <= d2;
        end else begin
          c_cand[e].k <= b_k[e];
          c_cand[e].d <= b_d[e];
        end
      end
    end
  end

  // two compare levels per tree stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        t1_cand[i] <= pick_nearer(pick_nearer(c_cand[4*i], c_cand[4*i+1]),
                                  pick_nearer(c_cand[4*i+2], c_cand[4*i+3]));
      end
      t2_cand <= pick_nearer(pick_nearer(t1_cand[0], t1_cand[1]),
                             pick_nearer(t1_cand[2], t1_cand[3]));
    end
  end

  // item side data and valid bits along the lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      a_item.vld  <= 1'b0;
      b_item.vld  <= 1'b0;
      c_item.vld  <= 1'b0;
      t1_item.vld <= 1'b0;
      t2_item.vld <= 1'b0;
    end else if (en) begin
      a_item.vld  <= dv_item.vld;
      b_item.vld  <= a_item.vld;
      c_item.vld  <= b_item.vld;
      t1_item.vld <= c_item.vld;
      t2_item.vld <= t1_item.vld;
    end
    if (en) begin
      a_item.target  <= dv_item.target;
      a_item.modem   <= dv_item.modem;
      b_item.target  <= a_item.target;
      b_item.modem   <= a_item.modem;
      c_item.target  <= b_item.target;
      c_item.modem   <= b_item.modem;
      t1_item.target <= c_item.target;
      t1_item.modem  <= c_item.modem;
      t2_item.target <= t1_item.target;
      t2_item.modem  <= t1_item.modem;
    end
  end

  // result formatting into the output register
  logic             res_ok;
  logic [EXP_W-1:0] res_e;
  logic [MANT_W-1:0] res_m;

  always_comb begin
    res_ok = (t2_item.target != '0);
    if (!res_ok || (crystal == '0)) begin
      res_e = '0;
      res_m = '0;
    end else begin
      res_e = t2_cand.e;
      res_m = t2_cand.k[MANT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= t2_item.vld;
    end
    if (en) begin
      rsp.valid_res         <= res_ok;
      rsp.rate_exponent     <= res_e;
      rsp.rate_mantissa     <= res_m;
      rsp.mantissa_byte_out <= res_m;
      rsp.modem_byte_out    <= res_ok ? {t2_item.modem[7:4], res_e} : {NIBBLE_ZERO, NIBBLE_ZERO};
    end
  end

  // a held result stays in place until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.valid_res)
                             && $stable(rsp.rate_exponent) && $stable(rsp.rate_mantissa))
    else $error("held result lost or changed");

  // an invalid result carries no exponent or mantissa
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.valid_res |-> rsp.rate_exponent == '0 && rsp.rate_mantissa == '0)
    else $error("zero target gave nonzero fields");

  // register bytes agree with the chosen pair
  a_bytes: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.modem_byte_out[3:0] == rsp.rate_exponent
              && rsp.mantissa_byte_out == rsp.rate_mantissa)
    else $error("register bytes disagree with exponent or mantissa");

endmodule
